### hw/rtl/rcra_pkg.sv
// types and constants shared by the rx completion ring assembler
`default_nettype none

package rcra_pkg;

	localparam int MAX_RING_DEPTH = 1024;
	localparam int DEPTH_W        = $clog2(MAX_RING_DEPTH + 1);
	localparam int SLOT_W         = $clog2(MAX_RING_DEPTH);
	localparam int LEN_W          = 16;
	localparam int RID_W          = 16;
	localparam int OFFS_W         = 8;
	localparam int TOTAL_W        = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = DEPTH_W;

	localparam logic [CFG_IDX_W-1:0] REG_RING_DEPTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_CHECK  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DESCS   = CFG_IDX_W'(2);

	localparam logic [DEPTH_W-1:0] MAX_DEPTH_VAL = DEPTH_W'(MAX_RING_DEPTH);
	localparam logic [DEPTH_W-1:0] RESET_MAX_DESCS = DEPTH_W'(32);

	typedef enum logic [2:0] {
		ST_EMPTY       = 3'd0,
		ST_TAKEN       = 3'd1,
		ST_DONE        = 3'd2,
		ST_STRAY_FIRST = 3'd3,
		ST_CORRUPT     = 3'd4,
		ST_TOO_MANY    = 3'd5,
		ST_BAD_ID      = 3'd6
	} status_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [SLOT_W-1:0]  mask;
		logic               zero_field_check;
		logic [DEPTH_W-1:0] max_descs;
	} cfg_t;

	typedef struct packed {
		logic              phase_bit;
		logic              first_flag;
		logic              last_flag;
		logic              zero_bits_set;
		logic [LEN_W-1:0]  buffer_length;
		logic [RID_W-1:0]  request_id;
		logic [OFFS_W-1:0] packet_offset;
	} desc_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot_index;
		logic [LEN_W-1:0]   out_length;
		logic [RID_W-1:0]   out_request_id;
		logic [SLOT_W-1:0]  packet_start;
		logic [DEPTH_W-1:0] packet_count;
		logic [OFFS_W-1:0]  out_offset;
		logic [TOTAL_W-1:0] completed_total;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/rcra_if.sv
// handshake channels of the rx completion ring assembler
`default_nettype none

interface rcra_desc_if;
	logic                          valid;
	logic                          ready;
	logic                          phase_bit;
	logic                          first_flag;
	logic                          last_flag;
	logic                          zero_bits_set;
	logic [rcra_pkg::LEN_W-1:0]    buffer_length;
	logic [rcra_pkg::RID_W-1:0]    request_id;
	logic [rcra_pkg::OFFS_W-1:0]   packet_offset;

	modport source (
		output valid, phase_bit, first_flag, last_flag, zero_bits_set,
		       buffer_length, request_id, packet_offset,
		input  ready
	);
	modport sink (
		input  valid, phase_bit, first_flag, last_flag, zero_bits_set,
		       buffer_length, request_id, packet_offset,
		output ready
	);
endinterface

interface rcra_cmpl_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    status;
	logic [rcra_pkg::SLOT_W-1:0]   slot_index;
	logic [rcra_pkg::LEN_W-1:0]    out_length;
	logic [rcra_pkg::RID_W-1:0]    out_request_id;
	logic [rcra_pkg::SLOT_W-1:0]   packet_start;
	logic [rcra_pkg::DEPTH_W-1:0]  packet_count;
	logic [rcra_pkg::OFFS_W-1:0]   out_offset;
	logic [rcra_pkg::TOTAL_W-1:0]  completed_total;

	modport source (
		output valid, status, slot_index, out_length, out_request_id,
		       packet_start, packet_count, out_offset, completed_total,
		input  ready
	);
	modport sink (
		input  valid, status, slot_index, out_length, out_request_id,
		       packet_start, packet_count, out_offset, completed_total,
		output ready
	);
endinterface

interface rcra_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rcra_pkg::CFG_IDX_W-1:0]   index;
	logic [rcra_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rcra_regs.sv
// configuration registers with derived ring depth and slot mask
`default_nettype none

module rcra_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rcra_cfg_if.sink           cfg,
	output rcra_pkg::cfg_t     cfg_out
);

	logic [rcra_pkg::DEPTH_W-1:0] eff_depth;

	assign cfg.ready = 1'b1;

	// zero or oversized depth falls back to the maximum
	always_comb begin
		if (cfg.data == '0 || cfg.data > rcra_pkg::MAX_DEPTH_VAL) begin
			eff_depth = rcra_pkg::MAX_DEPTH_VAL;
		end else begin
			eff_depth = cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_out.depth            <= rcra_pkg::MAX_DEPTH_VAL;
			cfg_out.mask             <= rcra_pkg::SLOT_W'(rcra_pkg::MAX_RING_DEPTH - 1);
			cfg_out.zero_field_check <= 1'b1;
			cfg_out.max_descs        <= rcra_pkg::RESET_MAX_DESCS;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				rcra_pkg::REG_RING_DEPTH: begin
					cfg_out.depth <= eff_depth;
					cfg_out.mask  <= rcra_pkg::SLOT_W'(eff_depth - 1'b1);
				end
				rcra_pkg::REG_ZERO_CHECK: begin
					cfg_out.zero_field_check <= cfg.data[0];
				end
				rcra_pkg::REG_MAX_DESCS: begin
					cfg_out.max_descs <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rcra_core.sv
// ring head, phase and packet state with the per-item update
`default_nettype none

module rcra_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rcra_pkg::cfg_t  cfg,
	input  wire logic            advance,
	input  wire rcra_pkg::desc_t desc,
	output rcra_pkg::result_t    result
);

	logic [rcra_pkg::SLOT_W-1:0]  head_q;
	logic                         phase_q;
	logic [rcra_pkg::DEPTH_W-1:0] count_q;
	logic [rcra_pkg::SLOT_W-1:0]  start_q;
	logic [rcra_pkg::OFFS_W-1:0]  offset_q;
	logic                         bad_id_q;
	logic [rcra_pkg::TOTAL_W-1:0] total_q;

	logic [rcra_pkg::SLOT_W-1:0]  head_inc;
	logic [rcra_pkg::SLOT_W-1:0]  next_slot;
	logic [rcra_pkg::DEPTH_W-1:0] count_inc;
	logic [rcra_pkg::OFFS_W-1:0]  offset_use;
	logic                         bad;
	logic                         consume;

	always_comb begin
		head_inc   = head_q + 1'b1;
		next_slot  = head_inc & cfg.mask;
		count_inc  = (count_q == rcra_pkg::MAX_DEPTH_VAL) ? count_q : count_q + 1'b1;
		offset_use = (count_q == '0) ? desc.packet_offset : offset_q;
		bad        = bad_id_q ||
		             (desc.request_id >= rcra_pkg::RID_W'(cfg.depth));
		consume    = 1'b0;

		result                 = '0;
		result.slot_index      = head_q & cfg.mask;
		result.completed_total = total_q;

		if (desc.phase_bit != phase_q) begin
			result.status = rcra_pkg::ST_EMPTY;
		end else if (desc.first_flag && count_q != '0) begin
			result.status = rcra_pkg::ST_STRAY_FIRST;
		end else if (desc.zero_bits_set && cfg.zero_field_check) begin
			result.status = rcra_pkg::ST_CORRUPT;
		end else begin
			consume               = 1'b1;
			result.out_length     = desc.buffer_length;
			result.out_request_id = desc.request_id;
			if (desc.last_flag) begin
				result.packet_start = start_q;
				result.packet_count = count_inc;
				result.out_offset   = offset_use;
				if (count_inc > cfg.max_descs) begin
					result.status = rcra_pkg::ST_TOO_MANY;
				end else if (bad) begin
					result.status = rcra_pkg::ST_BAD_ID;
				end else begin
					result.status          = rcra_pkg::ST_DONE;
					result.completed_total = total_q + rcra_pkg::TOTAL_W'(count_inc);
				end
			end else begin
				result.status = rcra_pkg::ST_TAKEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			phase_q  <= 1'b1;
			count_q  <= '0;
			start_q  <= '0;
			offset_q <= '0;
			bad_id_q <= 1'b0;
			total_q  <= '0;
		end else if (advance && consume) begin
			head_q   <= head_inc;
			offset_q <= offset_use;
			total_q  <= result.completed_total;
			if (next_slot == '0) begin
				phase_q <= ~phase_q;
			end
			if (desc.last_flag) begin
				count_q  <= '0;
				bad_id_q <= 1'b0;
				start_q  <= next_slot;
			end else begin
				count_q  <= count_inc;
				bad_id_q <= bad;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rx_completion_ring_assembler.sv
// top level of the rx completion ring assembler
//
// desc carries one decoded completion descriptor, the one at the current
// head slot, per item; cmpl returns exactly one result item per descriptor
// item, in order. cfg writes ring_depth (index 0), zero_field_check
// (index 1) and max_descs (index 2); it is always ready and should only be
// written while no descriptor is in flight.
// An accepted descriptor is held in the input register, which feeds the
// state update; that update loads the result register on each advance,
// and cmpl presents the result from the result register.
// Throughput is one item per cycle while the result register is empty or
// cmpl.ready is high, set by the head/phase/count update on each advance.
// A full result register with cmpl.ready low holds its item; the input
// register still takes one more item, after which desc.ready drops until
// the receiver takes the result.
// Reset sets head slot 0, expected phase 1, no packet open, completion
// total 0, and the registers to depth 1024, checking on, 32 descriptors.
`default_nettype none

module rx_completion_ring_assembler (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rcra_cfg_if.sink     cfg,
	rcra_desc_if.sink    desc,
	rcra_cmpl_if.source  cmpl
);

	rcra_pkg::cfg_t    cfg_cur;
	rcra_pkg::desc_t   desc_s1;
	rcra_pkg::result_t res_next;
	rcra_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	rcra_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	rcra_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_cur),
		.advance (advance),
		.desc    (desc_s1),
		.result  (res_next)
	);

	assign advance    = valid_s1 && (!valid_s2 || cmpl.ready);
	assign desc.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (desc.valid && desc.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (cmpl.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc.valid && desc.ready) begin
			desc_s1.phase_bit     <= desc.phase_bit;
			desc_s1.first_flag    <= desc.first_flag;
			desc_s1.last_flag     <= desc.last_flag;
			desc_s1.zero_bits_set <= desc.zero_bits_set;
			desc_s1.buffer_length <= desc.buffer_length;
			desc_s1.request_id    <= desc.request_id;
			desc_s1.packet_offset <= desc.packet_offset;
		end
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign cmpl.valid           = valid_s2;
	assign cmpl.status          = res_s2.status;
	assign cmpl.slot_index      = res_s2.slot_index;
	assign cmpl.out_length      = res_s2.out_length;
	assign cmpl.out_request_id  = res_s2.out_request_id;
	assign cmpl.packet_start    = res_s2.packet_start;
	assign cmpl.packet_count    = res_s2.packet_count;
	assign cmpl.out_offset      = res_s2.out_offset;
	assign cmpl.completed_total = res_s2.completed_total;

endmodule

`default_nettype wire
